@@ hdl/cgpm_pkg.sv @@
// Shared types, constants and decode helpers for the channel gain and peak meter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cgpm_pkg;

	// Channel count and peak format adjusts
	localparam int MAX_CHANNELS   = 8;
	localparam int PEAK_SHIFT_S16 = 16;
	localparam int PEAK_SHIFT_S24 = 8;
	localparam int CH_IDX_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	// Configuration port geometry and register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_FORMAT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PASSTHROUGH_MODE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_ATTENUATION = 2'd3;

	// Sample format codes (the unused code behaves as 32-bit)
	localparam logic [1:0] SF_S16 = 2'd0;
	localparam logic [1:0] SF_S24 = 2'd1;
	localparam logic [1:0] SF_S32 = 2'd2;

	// Gain format codes (the unused code behaves as Q1.31)
	localparam logic [1:0] GF_Q8_16 = 2'd0;
	localparam logic [1:0] GF_Q9_23 = 2'd1;
	localparam logic [1:0] GF_Q1_31 = 2'd2;

	localparam logic [30:0] PEAK_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [1:0] sample_format;
		logic [1:0] gain_format;
		logic       passthrough_mode;
		logic [4:0] peak_attenuation;
	} cfg_t;

	// Sign-extend the used low bits of a sample word
	function automatic logic signed [31:0] sext_sample(logic [31:0] raw, logic [1:0] fmt);
		unique case (fmt)
			SF_S16:  return {{16{raw[15]}}, raw[15:0]};
			SF_S24:  return {{8{raw[23]}}, raw[23:0]};
			default: return raw;
		endcase
	endfunction

	// Fraction bits of the gain word
	function automatic logic [4:0] frac_shift(logic [1:0] fmt);
		unique case (fmt)
			GF_Q8_16: return 5'd16;
			GF_Q9_23: return 5'd23;
			default:  return 5'd31;
		endcase
	endfunction

endpackage

@@ hdl/cgpm_peak_meter.sv @@
// Per-channel peak meter: magnitude, format shift with saturation, and the peak store.
// Depends on cgpm_pkg.
`timescale 1ns / 1ps

module cgpm_peak_meter
	import cgpm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                upd,
	input  logic [2:0]          channel,
	input  logic signed [31:0]  sample,
	output logic [30:0]         peak_new
);

	logic [30:0]         store_q [MAX_CHANNELS];
	logic [31:0]         ch_ext;
	logic                ch_ok;
	logic [CH_IDX_W-1:0] idx;
	logic [31:0]         mag;
	logic [5:0]          psh;
	logic [62:0]         shifted;
	logic [30:0]         pk;
	logic [30:0]         rd;
	logic                grow;

	assign ch_ext = 32'(channel);
	assign ch_ok  = ch_ext < 32'(MAX_CHANNELS);
	assign idx    = ch_ext[CH_IDX_W-1:0];

	// Absolute value; the most negative sample maps to 2^31
	assign mag = sample[31] ? (~sample + 32'd1) : sample;

	// Shift amount by format; attenuation only for 24 and 32 bit
	always_comb begin
		unique case (cfg.sample_format)
			SF_S16:  psh = 6'(PEAK_SHIFT_S16);
			SF_S24:  psh = 6'(PEAK_SHIFT_S24) + {1'b0, cfg.peak_attenuation};
			default: psh = {1'b0, cfg.peak_attenuation};
		endcase
	end

	assign shifted = {31'b0, mag} << psh[4:0];

	// Saturate the shifted magnitude at the 31-bit maximum
	always_comb begin
		if (mag == 32'd0) begin
			pk = '0;
		end else if (psh[5] || (shifted[62:31] != 32'd0)) begin
			pk = PEAK_MAX;
		end else begin
			pk = shifted[30:0];
		end
	end

	assign rd       = store_q[idx];
	assign grow     = ch_ok && (pk > rd);
	assign peak_new = !ch_ok ? 31'd0 : (grow ? pk : rd);

	// Peak store, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				store_q[i] <= '0;
			end
		end else if (upd && grow) begin
			store_q[idx] <= pk;
		end
	end

	// A stored peak only ever grows
	a_peak_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && grow) |-> (pk > rd))
		else $error("peak store written with a smaller value");

	// The reported peak of a valid channel is what the store holds afterwards
	a_peak_written: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && ch_ok) |=> (store_q[$past(idx)] == $past(peak_new)))
		else $error("peak store does not match reported peak");

endmodule

@@ hdl/cgpm_round_sat.sv @@
// Output stage logic: round-to-nearest, arithmetic shift, saturation and passthrough.
// Depends on cgpm_pkg.
`timescale 1ns / 1ps

module cgpm_round_sat
	import cgpm_pkg::*;
(
	input  cfg_t               cfg,
	input  logic signed [63:0] prod,
	input  logic [31:0]        raw,
	output logic [31:0]        sample
);

	logic [4:0]         fsh;
	logic signed [63:0] rnd;
	logic signed [63:0] sum;
	logic signed [63:0] scaled;
	logic signed [63:0] lo;
	logic signed [63:0] hi;
	logic signed [63:0] clamped;

	assign fsh    = frac_shift(cfg.gain_format);
	assign rnd    = 64'(1) << (fsh - 5'd1);
	// Product magnitude is at most 2^62, so the add cannot overflow
	assign sum    = prod + rnd;
	assign scaled = sum >>> fsh;

	// Limits of the sample format
	always_comb begin
		unique case (cfg.sample_format)
			SF_S16: begin
				lo = -64'sd32768;
				hi = 64'sd32767;
			end
			SF_S24: begin
				lo = -64'sd8388608;
				hi = 64'sd8388607;
			end
			default: begin
				lo = -64'sd2147483648;
				hi = 64'sd2147483647;
			end
		endcase
	end

	always_comb begin
		if (scaled < lo) begin
			clamped = lo;
		end else if (scaled > hi) begin
			clamped = hi;
		end else begin
			clamped = scaled;
		end
	end

	assign sample = cfg.passthrough_mode ? raw : clamped[31:0];

endmodule

@@ hdl/channel_gain_with_peak_meter_core.sv @@
// Top level of the channel gain and peak meter: config registers and a three-register pipeline.
// Depends on cgpm_pkg, cgpm_peak_meter and cgpm_round_sat.
//
//   channel   handshake            payload
//   -------   ------------------   ---------------------------------
//   input     in_valid / in_stall  sample_in, channel, gain
//   output    out_valid/out_stall  sample_out, channel_peak
//   config    cfg_we               cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low. An accepted item reaches the output
// through the input register, the product register after the 32x32 multiplier and the result register.
// The peak store is updated as an item leaves the input register, so items see
// peaks in arrival order. Reset clears the peak store and sets the config to its defaults at once.
// Stalls back up one stage at a time; in_stall rises only with all stages full.
`timescale 1ns / 1ps

module channel_gain_with_peak_meter_core
	import cgpm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [31:0]    sample_in,
	input  logic [2:0]            channel,
	input  logic signed [31:0]    gain,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [31:0]    sample_out,
	output logic [30:0]           channel_peak
);

	cfg_t               cfg_q;
	logic               v_s1;
	logic [31:0]        raw_s1;
	logic [2:0]         channel_s1;
	logic signed [31:0] gain_s1;
	logic               v_s2;
	logic signed [63:0] prod_s2;
	logic [31:0]        raw_s2;
	logic [30:0]        peak_s2;
	logic               out_valid_q;
	logic [31:0]        sample_out_q;
	logic [30:0]        channel_peak_q;
	logic               ready_out;
	logic               ready_s2;
	logic               ready_s1;
	logic signed [31:0] x_s1;
	logic signed [63:0] prod;
	logic [30:0]        peak_new;
	logic [31:0]        result;

	// Config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_format    <= SF_S32;
			cfg_q.gain_format      <= GF_Q8_16;
			cfg_q.passthrough_mode <= 1'b0;
			cfg_q.peak_attenuation <= 5'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLE_FORMAT:    cfg_q.sample_format    <= cfg_data[1:0];
				REG_GAIN_FORMAT:      cfg_q.gain_format      <= cfg_data[1:0];
				REG_PASSTHROUGH_MODE: cfg_q.passthrough_mode <= cfg_data[0];
				REG_PEAK_ATTENUATION: cfg_q.peak_attenuation <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Per-stage flow control
	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s2  = !v_s2 || ready_out;
	assign ready_s1  = !v_s1 || ready_s2;
	assign in_stall  = !ready_s1;

	// Stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			raw_s1     <= sample_in;
			channel_s1 <= channel;
			gain_s1    <= gain;
		end
	end

	// Multiply and peak update
	assign x_s1 = sext_sample(raw_s1, cfg_q.sample_format);
	assign prod = 64'(x_s1) * 64'(gain_s1);

	cgpm_peak_meter u_peak (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.upd      (v_s1 && ready_s2),
		.channel  (channel_s1),
		.sample   (x_s1),
		.peak_new (peak_new)
	);

	// Stage 2: product register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && ready_s2) begin
			prod_s2 <= prod;
			raw_s2  <= raw_s1;
			peak_s2 <= peak_new;
		end
	end

	cgpm_round_sat u_round (
		.cfg    (cfg_q),
		.prod   (prod_s2),
		.raw    (raw_s2),
		.sample (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && ready_out) begin
			sample_out_q   <= result;
			channel_peak_q <= peak_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_out   = sample_out_q;
	assign channel_peak = channel_peak_q;

	// Input only backs up when every stage holds an item and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && out_valid_q && out_stall))
		else $error("input stalled with a free pipeline stage");

	// An item in stage 1 moves to stage 2 when it may
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && ready_s2) |=> v_s2)
		else $error("stage 1 item lost");

	// A taken result with nothing behind it leaves the output empty
	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !v_s2) |=> !out_valid_q)
		else $error("result repeated after it was taken");

endmodule
